FILE: src/pump_fault_qualifier_core_defines.svh
// assertion macros shared by the pump fault qualifier rtl
`ifndef PUMP_FAULT_QUALIFIER_CORE_DEFINES_SVH
`define PUMP_FAULT_QUALIFIER_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define PFQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("pump fault qualifier assertion failed");

// next-cycle implication, disabled while reset is asserted
`define PFQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("pump fault qualifier assertion failed");

`endif

FILE: src/pfq_pkg.sv
// types and constants of the pump fault qualifier
package pfq_pkg;

	typedef enum logic [2:0] {
		PEND_NONE = 3'd0,
		PEND_OVER = 3'd1,
		PEND_DRY  = 3'd2,
		PEND_NOTW = 3'd3,
		PEND_LINE = 3'd4
	} pend_t;

	typedef enum logic [1:0] {
		CFG_NOMINAL  = 2'd0,
		CFG_CT_CHECK = 2'd1,
		CFG_QUALIFY  = 2'd2
	} cfg_idx_t;

	localparam int WORD_W = 10;
	localparam int CFG_W  = 16;

	// status word bit positions
	localparam logic [3:0] BIT_MANUAL = 4'd0;
	localparam logic [3:0] BIT_AUTO   = 4'd1;
	localparam logic [3:0] BIT_OVER   = 4'd2;
	localparam logic [3:0] BIT_DRY    = 4'd3;
	localparam logic [3:0] BIT_NOTW   = 4'd4;
	localparam logic [3:0] BIT_R      = 4'd5;
	localparam logic [3:0] BIT_Y      = 4'd6;
	localparam logic [3:0] BIT_B      = 4'd7;
	localparam logic [3:0] BIT_LINE   = 4'd8;
	localparam logic [3:0] BIT_RUN    = 4'd9;

	// threshold multipliers of the per-cent unit
	localparam int K_OVER    = 32;
	localparam int K_DRY_HI  = 58;
	localparam int K_STOP    = 15;
	localparam int K_NOTW    = 20;
	localparam int K_RUN_ON  = 18;

	// floor(x / 100) for 16 bit x as (x * RECIP_100) >> RECIP_SHIFT
	localparam logic [16:0] RECIP_100   = 17'd83887;
	localparam int          RECIP_SHIFT = 23;
	localparam int          UNIT_W      = 10;

	localparam logic [7:0] COUNT_MAX     = 8'd255;
	localparam logic [7:0] QUALIFY_RESET = 8'd3;

	typedef struct packed {
		logic [WORD_W-1:0] status;
		pend_t             pend;
		logic [7:0]        count;
	} qstate_t;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic              changed;
		logic              fault_lamp;
		logic              supply_ok_lamp;
	} result_t;

endpackage

FILE: src/pump_fault_qualifier_core.sv
// pump fault qualifier top level: fault qualification on held current and phase inputs
// an accepted item is held in the input register, then moves on to the output register
// throughput: one item per cycle while out_stall is low; the state update is a single pass of compare logic
// the per-cent unit of the nominal current is computed once, when that register is written
// reset: async active low, clears state, pending code, counter and status/reported words
// reset config: nominal 0, current checks off, qualify count 3
module pump_fault_qualifier_core #(
	parameter int CURRENT_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// config write port
	input  logic                          wr_en,
	input  logic [1:0]                    wr_index,
	input  logic [pfq_pkg::CFG_W-1:0]     wr_data,
	// input channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          sample_valid,
	input  logic [CURRENT_BITS-1:0]       run_current,
	input  logic                          start_delay_done,
	input  logic                          pump_commanded_on,
	input  logic                          phase_r_ok,
	input  logic                          phase_y_ok,
	input  logic                          phase_b_ok,
	input  logic                          auto_switch,
	input  logic                          relay_pin_level,
	// result channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          auto_mode,
	output logic                          overload_fault,
	output logic                          dry_run_fault,
	output logic                          not_working_fault,
	output logic                          phase_r_status,
	output logic                          phase_y_status,
	output logic                          phase_b_status,
	output logic                          line_fault,
	output logic                          pump_running,
	output logic                          status_changed,
	output logic                          fault_lamp,
	output logic                          supply_ok_lamp
);
	import pfq_pkg::*;

	`include "pump_fault_qualifier_core_defines.svh"

	// compare width: holds the widest current and the overload threshold
	localparam int CMP_W = (CURRENT_BITS > 17) ? CURRENT_BITS : 17;
	// nominal is a 16 bit register, further limited to the current width
	localparam logic [15:0] NOM_MASK = (CURRENT_BITS >= 16) ? 16'hFFFF :
		16'((32'd1 << CURRENT_BITS) - 32'd1);

	// ---------------------------------------------------------------
	// configuration registers and the derived per-cent unit
	// ---------------------------------------------------------------
	logic [15:0]       nominal_q;
	logic              ct_check_q;
	logic [7:0]        qualify_q;
	logic [UNIT_W-1:0] unit_q;

	logic [15:0] nom_wr;
	logic [32:0] unit_prod;

	assign nom_wr    = wr_data[15:0] & NOM_MASK;
	// reciprocal multiply: exact floor division by 100 over 16 bit inputs
	assign unit_prod = 33'(nom_wr) * 33'(RECIP_100);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nominal_q  <= '0;
			ct_check_q <= 1'b0;
			qualify_q  <= QUALIFY_RESET;
			unit_q     <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_NOMINAL: begin
					nominal_q <= nom_wr;
					unit_q    <= unit_prod[RECIP_SHIFT +: UNIT_W];
				end
				CFG_CT_CHECK: ct_check_q <= wr_data[0];
				CFG_QUALIFY:  qualify_q  <= wr_data[7:0];
				default: ;    // index beyond the register list is ignored
			endcase
		end
	end

	// ---------------------------------------------------------------
	// handshake: input register feeds the result register in one pass
	// ---------------------------------------------------------------
	logic adv;     // result register can take a new item
	logic s1_valid_q;

	assign adv      = !out_valid || !out_stall;
	assign in_stall = s1_valid_q && !adv;

	logic                    sample_s1;
	logic [CURRENT_BITS-1:0] current_s1;
	logic                    settled_s1;
	logic                    cmd_on_s1;
	logic                    pr_s1;
	logic                    py_s1;
	logic                    pb_s1;
	logic                    autosw_s1;
	logic                    relay_off_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (!in_stall) begin
			s1_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			sample_s1    <= sample_valid;
			current_s1   <= run_current;
			settled_s1   <= start_delay_done;
			cmd_on_s1    <= pump_commanded_on;
			pr_s1        <= phase_r_ok;
			py_s1        <= phase_y_ok;
			pb_s1        <= phase_b_ok;
			autosw_s1    <= auto_switch;
			relay_off_s1 <= relay_pin_level;
		end
	end

	// ---------------------------------------------------------------
	// qualifier state
	// ---------------------------------------------------------------
	logic [CURRENT_BITS-1:0] held_q;
	qstate_t                 qs_q;
	logic [WORD_W-1:0]       rep_q;   // word last reported

	// one fault: arm and latch while the condition holds, clear otherwise
	function automatic qstate_t qualify(qstate_t s, logic cond, logic arm,
			logic [3:0] pos, pend_t code, logic rst_cnt, logic [7:0] qc);
		qstate_t r;
		r = s;
		if (cond) begin
			if (arm && !s.status[pos]) begin
				r.pend = code;
				if (s.count > qc) begin
					r.status[pos] = 1'b1;
					r.count       = '0;
				end
			end
		end else begin
			r.status[pos] = 1'b0;
			if (s.pend == code) begin
				if (rst_cnt) begin
					r.count = '0;
				end
				r.pend = PEND_NONE;
			end
		end
		return r;
	endfunction

	logic [CURRENT_BITS-1:0] cur;
	logic [CMP_W-1:0]        cur_x;
	logic [CMP_W-1:0]        unit_x;
	logic [CMP_W-1:0]        th_over;
	logic [CMP_W-1:0]        th_dry_hi;
	logic [CMP_W-1:0]        th_stop;
	logic [CMP_W-1:0]        th_notw;
	logic [CMP_W-1:0]        th_run_on;
	logic                    gate;
	logic                    all_phases;
	qstate_t                 qs_n;
	result_t                 res;

	assign cur       = sample_s1 ? current_s1 : held_q;
	assign cur_x     = CMP_W'(cur);
	assign unit_x    = CMP_W'(unit_q);
	// thresholds are small constant multiples of the unit; overload adds the nominal to its multiple
	assign th_over   = CMP_W'(nominal_q) + (unit_x * CMP_W'(K_OVER));
	assign th_dry_hi = unit_x * CMP_W'(K_DRY_HI);
	assign th_stop   = unit_x * CMP_W'(K_STOP);
	assign th_notw   = unit_x * CMP_W'(K_NOTW);
	assign th_run_on = unit_x * CMP_W'(K_RUN_ON);
	assign gate      = settled_s1 && ct_check_q;
	assign all_phases = pr_s1 && py_s1 && pb_s1;

	always_comb begin
		qs_n = qs_q;

		// a new sample advances the counter when a fault was pending, and clears it otherwise
		if (sample_s1) begin
			if (qs_n.pend != PEND_NONE) begin
				qs_n.pend = PEND_NONE;
				if (qs_n.count != COUNT_MAX) begin
					qs_n.count = qs_n.count + 8'd1;
				end
			end else begin
				qs_n.count = '0;
			end
		end

		qs_n.status[BIT_AUTO]   = autosw_s1;
		qs_n.status[BIT_MANUAL] = !autosw_s1;

		qs_n = qualify(qs_n, gate && (cur_x > th_over), 1'b1,
			BIT_OVER, PEND_OVER, 1'b1, qualify_q);
		// dry run arms only above the not-working level
		qs_n = qualify(qs_n, gate && (cur_x < th_dry_hi) && (cur_x > th_stop),
			cur_x > th_notw, BIT_DRY, PEND_DRY, 1'b1, qualify_q);
		qs_n = qualify(qs_n, gate && cmd_on_s1 && (cur_x < th_notw), 1'b1,
			BIT_NOTW, PEND_NOTW, 1'b1, qualify_q);

		qs_n.status[BIT_R] = pr_s1;
		qs_n.status[BIT_Y] = py_s1;
		qs_n.status[BIT_B] = pb_s1;

		// line fault keeps the counter when it clears
		qs_n = qualify(qs_n, !all_phases, 1'b1,
			BIT_LINE, PEND_LINE, 1'b0, qualify_q);

		// running status: current hysteresis, or relay readback without checks
		if (ct_check_q) begin
			if ((cur_x < th_stop) && qs_n.status[BIT_RUN]) begin
				qs_n.status[BIT_RUN] = 1'b0;
				qs_n.pend            = PEND_NONE;
				qs_n.count           = '0;
			end
			if ((cur_x > th_run_on) && !qs_n.status[BIT_RUN]) begin
				qs_n.status[BIT_RUN] = 1'b1;
			end
		end else begin
			qs_n.status[BIT_RUN] = !relay_off_s1;
		end

		res.word           = qs_n.status;
		res.changed        = (rep_q != qs_n.status);
		res.supply_ok_lamp = qs_n.status[BIT_R] && qs_n.status[BIT_Y] &&
			qs_n.status[BIT_B];
		res.fault_lamp     = qs_n.status[BIT_DRY] || qs_n.status[BIT_LINE] ||
			qs_n.status[BIT_OVER] || qs_n.status[BIT_NOTW] || !res.supply_ok_lamp;
	end

	logic fire;   // the item in the input register moves to the result register
	assign fire = s1_valid_q && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			qs_q   <= '{status: '0, pend: PEND_NONE, count: '0};
			rep_q  <= '0;
		end else if (fire) begin
			if (sample_s1) begin
				held_q <= current_s1;
			end
			qs_q  <= qs_n;
			rep_q <= qs_n.status;
		end
	end

	// ---------------------------------------------------------------
	// result register
	// ---------------------------------------------------------------
	result_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res;
		end
	end

	assign auto_mode         = res_q.word[BIT_AUTO];
	assign overload_fault    = res_q.word[BIT_OVER];
	assign dry_run_fault     = res_q.word[BIT_DRY];
	assign not_working_fault = res_q.word[BIT_NOTW];
	assign phase_r_status    = res_q.word[BIT_R];
	assign phase_y_status    = res_q.word[BIT_Y];
	assign phase_b_status    = res_q.word[BIT_B];
	assign line_fault        = res_q.word[BIT_LINE];
	assign pump_running      = res_q.word[BIT_RUN];
	assign status_changed    = res_q.changed;
	assign fault_lamp        = res_q.fault_lamp;
	assign supply_ok_lamp    = res_q.supply_ok_lamp;

	// ---------------------------------------------------------------
	// assertions
	// ---------------------------------------------------------------
	// the reported word tracks the word of the newest result
	`PFQ_ASSERT_IMPL(a_reported_matches, clk, arst_n, out_valid, rep_q == res_q.word)
	// overload and not-working need opposite current levels
	`PFQ_ASSERT_IMPL(a_over_notw_excl, clk, arst_n, out_valid,
		!(overload_fault && not_working_fault))
	// current faults stay clear while current checks are off
	`PFQ_ASSERT_IMPL(a_ct_off_no_current_fault, clk, arst_n, out_valid && !ct_check_q,
		!(overload_fault || dry_run_fault || not_working_fault))
	// a latched line fault means a phase is missing
	`PFQ_ASSERT_IMPL(a_line_needs_missing_phase, clk, arst_n, out_valid && line_fault,
		!(phase_r_status && phase_y_status && phase_b_status))

endmodule
